// ===== hw/rtl/rcu_pkg.sv =====
// Shared types and constants of the RMSprop clipped update unit.
package rcu_pkg;

   localparam int unsigned ROOT_W  = 32;
   localparam int unsigned SQIN_W  = 64;
   localparam int unsigned NUM_W   = 55;
   localparam int unsigned DEN_W   = 33;
   localparam int unsigned QUOT_W  = 34;
   localparam int unsigned CACHE_W = 48;

   localparam logic [24:0] ONE_Q24 = 25'h100_0000;
   localparam logic [QUOT_W-1:0] STEP_LIMIT = 34'h2_0000_0000;
   localparam logic [CACHE_W-1:0] CACHE_MAX = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] REG_STEP_RATE    = 3'd0;
   localparam logic [2:0] REG_DECAY        = 3'd1;
   localparam logic [2:0] REG_CLIP_LIMIT   = 3'd2;
   localparam logic [2:0] REG_WEIGHT_DECAY = 3'd3;
   localparam logic [2:0] REG_EPSILON      = 3'd4;

   localparam logic [24:0] RST_STEP_RATE    = 25'd167772;
   localparam logic [24:0] RST_DECAY        = 25'd16760439;
   localparam logic [30:0] RST_CLIP_LIMIT   = 31'd83886080;
   localparam logic [31:0] RST_WEIGHT_DECAY = 32'd4295;
   localparam logic [31:0] RST_EPSILON      = 32'd43;

   // Per-request data that rides alongside the root and divide pipelines.
   typedef struct packed {
      logic signed [31:0] weight;
      logic [30:0]        reg_mag;
      logic               grad_neg;
      logic               clipped;
      logic [47:0]        cache_new;
      logic [31:0]        clip_total;
      logic [31:0]        elem_total;
   } tail_type;

endpackage

// ===== hw/rtl/rcu_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module rcu_sqrt_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rcu_pkg::SQIN_W-1:0]    in_x,
   input  logic [rcu_pkg::NUM_W-1:0]     in_num,
   input  rcu_pkg::tail_type             in_tail,
   output logic                          out_valid,
   output logic [rcu_pkg::ROOT_W-1:0]    out_root,
   output logic [rcu_pkg::NUM_W-1:0]     out_num,
   output rcu_pkg::tail_type             out_tail
);

   localparam int unsigned N = rcu_pkg::ROOT_W;

   logic                          valid_ff [N];
   logic [N+1:0]                  rem_ff   [N];
   logic [N-1:0]                  root_ff  [N];
   logic [rcu_pkg::SQIN_W-1:0]    x_ff     [N];
   logic [rcu_pkg::NUM_W-1:0]     num_ff   [N];
   rcu_pkg::tail_type             tail_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                       valid_src;
      logic [N+1:0]               rem_src;
      logic [N-1:0]               root_src;
      logic [rcu_pkg::SQIN_W-1:0] x_src;
      logic [rcu_pkg::NUM_W-1:0]  num_src;
      rcu_pkg::tail_type          tail_src;
      logic [N+3:0]               rem_cat;
      logic [N+3:0]               trial;
      logic [N+1:0]               rem_in;
      logic [N-1:0]               root_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign x_src     = in_x;
         assign num_src   = in_num;
         assign tail_src  = in_tail;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign x_src     = x_ff[k-1];
         assign num_src   = num_ff[k-1];
         assign tail_src  = tail_ff[k-1];
      end

      always_comb begin
         rem_cat = {rem_src, x_src[rcu_pkg::SQIN_W-1 -: 2]};
         trial   = {2'b00, root_src, 2'b01};
         if (rem_cat >= trial) begin
            rem_in  = (N+2)'(rem_cat - trial);
            root_in = {root_src[N-2:0], 1'b1};
         end else begin
            rem_in  = (N+2)'(rem_cat);
            root_in = {root_src[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            x_ff[k]    <= {x_src[rcu_pkg::SQIN_W-3:0], 2'b00};
            num_ff[k]  <= num_src;
            tail_ff[k] <= tail_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_num   = num_ff[N-1];
   assign out_tail  = tail_ff[N-1];

endmodule

// ===== hw/rtl/rcu_div_pipe.sv =====
// Pipelined restoring divider for the step magnitude, saturated at the step limit.
module rcu_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [rcu_pkg::NUM_W-1:0]     in_num,
   input  logic [rcu_pkg::ROOT_W-1:0]    in_root,
   input  rcu_pkg::tail_type             in_tail,
   output logic                          out_valid,
   output logic [rcu_pkg::QUOT_W-1:0]    out_step,
   output rcu_pkg::tail_type             out_tail
);

   localparam int unsigned N  = rcu_pkg::QUOT_W;
   localparam int unsigned DW = rcu_pkg::DEN_W;

   logic                  valid_ff [N];
   logic                  sat_ff   [N];
   logic [DW:0]           rem_ff   [N];
   logic [DW-1:0]         den_ff   [N];
   logic [N-1:0]          low_ff   [N];
   logic [N-1:0]          quot_ff  [N];
   rcu_pkg::tail_type     tail_ff  [N];

   logic [DW-1:0] den_entry;
   logic          sat_entry;
   logic [DW:0]   rem_entry;

   // A zero root with a nonzero numerator, or a quotient of 2^34 or more,
   // saturates the step; both are known before the first step. A zero root
   // divides by all ones instead, so that a zero numerator still gives a zero step.
   always_comb begin
      rem_entry = (DW+1)'(in_num[rcu_pkg::NUM_W-1:N]);
      if (in_root == '0) begin
         den_entry = '1;
         sat_entry = (in_num != '0);
      end else begin
         den_entry = {in_root, 1'b0};
         sat_entry = ((DW+1)'(in_num[rcu_pkg::NUM_W-1:N]) >= {1'b0, den_entry});
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic              valid_src;
      logic              sat_src;
      logic [DW:0]       rem_src;
      logic [DW-1:0]     den_src;
      logic [N-1:0]      low_src;
      logic [N-1:0]      quot_src;
      rcu_pkg::tail_type tail_src;
      logic [DW+1:0]     rem_cat;
      logic [DW:0]       rem_in;
      logic              qbit;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign sat_src   = sat_entry;
         assign rem_src   = rem_entry;
         assign den_src   = den_entry;
         assign low_src   = in_num[N-1:0];
         assign quot_src  = '0;
         assign tail_src  = in_tail;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign sat_src   = sat_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign low_src   = low_ff[k-1];
         assign quot_src  = quot_ff[k-1];
         assign tail_src  = tail_ff[k-1];
      end

      always_comb begin
         rem_cat = {rem_src, low_src[N-1]};
         if (rem_cat >= (DW+2)'(den_src)) begin
            qbit   = 1'b1;
            rem_in = (DW+1)'(rem_cat - (DW+2)'(den_src));
         end else begin
            qbit   = 1'b0;
            rem_in = (DW+1)'(rem_cat);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[k]  <= sat_src;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            low_ff[k]  <= {low_src[N-2:0], 1'b0};
            quot_ff[k] <= {quot_src[N-2:0], qbit};
            tail_ff[k] <= tail_src;
         end
      end
   end

   always_comb begin
      if (sat_ff[N-1] || (quot_ff[N-1] > rcu_pkg::STEP_LIMIT)) begin
         out_step = rcu_pkg::STEP_LIMIT;
      end else begin
         out_step = quot_ff[N-1];
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_tail  = tail_ff[N-1];

endmodule

// ===== hw/rtl/rmsprop_clipped_update_unit.sv =====
// Top level of the RMSprop parameter update unit with gradient clipping.
// The unit takes one parameter element per clock while req_stall is low, and
// presents its updated weight and cache through 71 register
// stages: four for clipping, the multiplies and the saturated cache sum, a
// 32-stage square-root pipeline, a 34-stage divide pipeline and the output
// register. The whole pipeline advances together; when a result is
// stalled at the output, req_stall rises in the same cycle and nothing in
// flight is lost. Counters are updated as requests enter, so every result carries
// the totals of its own pass up to and including that element. Configuration is to
// be written over the APB-style port while no request is in flight (not enforced).
module rmsprop_clipped_update_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_pass,
   input  logic signed [31:0] req_weight_in,
   input  logic signed [31:0] req_grad_in,
   input  logic [47:0]        req_cache_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_weight_out,
   output logic [47:0]        rsp_cache_out,
   output logic               rsp_was_clipped,
   output logic [31:0]        rsp_clipped_total,
   output logic [31:0]        rsp_element_total,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Configuration registers.
   logic [24:0] step_rate_ff, decay_ff;
   logic [30:0] clip_limit_ff;
   logic [31:0] weight_decay_ff, epsilon_ff;
   logic        cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_rate_ff    <= rcu_pkg::RST_STEP_RATE;
         decay_ff        <= rcu_pkg::RST_DECAY;
         clip_limit_ff   <= rcu_pkg::RST_CLIP_LIMIT;
         weight_decay_ff <= rcu_pkg::RST_WEIGHT_DECAY;
         epsilon_ff      <= rcu_pkg::RST_EPSILON;
      end else if (cfg_write) begin
         unique case (paddr[4:2])
            rcu_pkg::REG_STEP_RATE:    step_rate_ff    <= pwdata[24:0];
            rcu_pkg::REG_DECAY:        decay_ff        <= pwdata[24:0];
            rcu_pkg::REG_CLIP_LIMIT:   clip_limit_ff   <= pwdata[30:0];
            rcu_pkg::REG_WEIGHT_DECAY: weight_decay_ff <= pwdata;
            rcu_pkg::REG_EPSILON:      epsilon_ff      <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         rcu_pkg::REG_STEP_RATE:    prdata = {7'd0, step_rate_ff};
         rcu_pkg::REG_DECAY:        prdata = {7'd0, decay_ff};
         rcu_pkg::REG_CLIP_LIMIT:   prdata = {1'b0, clip_limit_ff};
         rcu_pkg::REG_WEIGHT_DECAY: prdata = weight_decay_ff;
         rcu_pkg::REG_EPSILON:      prdata = epsilon_ff;
         default:                   prdata = '0;
      endcase
   end

   // Fractions above one are taken as one.
   logic [24:0] rate, dec, odec;
   assign rate = (step_rate_ff > rcu_pkg::ONE_Q24) ? rcu_pkg::ONE_Q24 : step_rate_ff;
   assign dec  = (decay_ff > rcu_pkg::ONE_Q24) ? rcu_pkg::ONE_Q24 : decay_ff;
   assign odec = rcu_pkg::ONE_Q24 - dec;

   logic en, accept, rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // Stage 1: clipping and counters.
   logic [31:0] gmag, wmag_in;
   logic [30:0] gcm_in;
   logic        clipped_in;
   logic [31:0] clip_cnt_ff, elem_cnt_ff, clip_base, elem_base, clip_cnt_in, elem_cnt_in;

   always_comb begin
      gmag       = req_grad_in[31] ? (~req_grad_in + 32'd1) : req_grad_in;
      wmag_in    = req_weight_in[31] ? (~req_weight_in + 32'd1) : req_weight_in;
      clipped_in = (gmag > {1'b0, clip_limit_ff});
      gcm_in     = clipped_in ? clip_limit_ff : gmag[30:0];
      clip_base  = req_start_pass ? '0 : clip_cnt_ff;
      elem_base  = req_start_pass ? '0 : elem_cnt_ff;
      clip_cnt_in = clip_base + {31'd0, clipped_in};
      elem_cnt_in = elem_base + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_cnt_ff <= '0;
         elem_cnt_ff <= '0;
      end else if (accept) begin
         clip_cnt_ff <= clip_cnt_in;
         elem_cnt_ff <= elem_cnt_in;
      end
   end

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [31:0] s1_w_ff, s2_w_ff, s3_w_ff, s4_w_ff;
   logic [31:0]        s1_gmag_ff, s1_wmag_ff;
   logic [30:0]        s1_gcm_ff;
   logic               s1_gneg_ff, s2_gneg_ff, s3_gneg_ff, s4_gneg_ff;
   logic               s1_clip_ff, s2_clip_ff, s3_clip_ff, s4_clip_ff;
   logic [47:0]        s1_cache_ff;
   logic [31:0]        s1_ct_ff, s2_ct_ff, s3_ct_ff, s4_ct_ff;
   logic [31:0]        s1_et_ff, s2_et_ff, s3_et_ff, s4_et_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_w_ff     <= req_weight_in;
         s1_gmag_ff  <= gmag;
         s1_wmag_ff  <= wmag_in;
         s1_gcm_ff   <= gcm_in;
         s1_gneg_ff  <= req_grad_in[31];
         s1_clip_ff  <= clipped_in;
         s1_cache_ff <= req_cache_in;
         s1_ct_ff    <= clip_cnt_in;
         s1_et_ff    <= elem_cnt_in;
      end
   end

   // Stage 2: gradient square, step numerator, regularization, cache decay products.
   logic [63:0] s2_g2_ff, regp;
   logic [54:0] s2_num_ff, s3_num_ff, s4_num_ff;
   logic [30:0] s2_reg_ff, s3_reg_ff, s4_reg_ff;
   logic [48:0] s2_cphi_ff;
   logic [24:0] s2_cplo_ff;
   logic [48:0] cplo_full;

   assign regp      = 64'(weight_decay_ff) * 64'(s1_wmag_ff);
   assign cplo_full = 49'(s1_cache_ff[23:0]) * 49'(dec);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_g2_ff   <= 64'(s1_gmag_ff) * 64'(s1_gmag_ff);
         s2_num_ff  <= 55'(rate) * 55'(s1_gcm_ff);
         s2_reg_ff  <= regp[62:32];
         s2_cphi_ff <= 49'(s1_cache_ff[47:24]) * 49'(dec);
         s2_cplo_ff <= cplo_full[48:24];
         s2_w_ff    <= s1_w_ff;
         s2_gneg_ff <= s1_gneg_ff;
         s2_clip_ff <= s1_clip_ff;
         s2_ct_ff   <= s1_ct_ff;
         s2_et_ff   <= s1_et_ff;
      end
   end

   // Stage 3: decayed cache and the pieces of the gradient term.
   logic [48:0] s3_t1_ff;
   logic [47:0] s3_gh_ff;
   logic [44:0] s3_ga_ff, s3_gb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_t1_ff   <= s2_cphi_ff + 49'(s2_cplo_ff);
         s3_gh_ff   <= 48'(s2_g2_ff[62:40]) * 48'(odec);
         s3_ga_ff   <= 45'(s2_g2_ff[39:20]) * 45'(odec);
         s3_gb_ff   <= 45'(s2_g2_ff[19:0]) * 45'(odec);
         s3_num_ff  <= s2_num_ff;
         s3_reg_ff  <= s2_reg_ff;
         s3_w_ff    <= s2_w_ff;
         s3_gneg_ff <= s2_gneg_ff;
         s3_clip_ff <= s2_clip_ff;
         s3_ct_ff   <= s2_ct_ff;
         s3_et_ff   <= s2_et_ff;
      end
   end

   // Stage 4: new cache, saturated.
   logic [65:0] glo_sum;
   logic [49:0] cnew_full;
   logic [47:0] s4_cnew_ff;

   always_comb begin
      glo_sum   = {s3_ga_ff, 20'd0} + 66'(s3_gb_ff);
      cnew_full = 50'(s3_t1_ff) + 50'(s3_gh_ff) + 50'(glo_sum[65:40]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_cnew_ff <= (cnew_full > 50'(rcu_pkg::CACHE_MAX)) ? rcu_pkg::CACHE_MAX
                                                            : cnew_full[47:0];
         s4_num_ff  <= s3_num_ff;
         s4_reg_ff  <= s3_reg_ff;
         s4_w_ff    <= s3_w_ff;
         s4_gneg_ff <= s3_gneg_ff;
         s4_clip_ff <= s3_clip_ff;
         s4_ct_ff   <= s3_ct_ff;
         s4_et_ff   <= s3_et_ff;
      end
   end

   // Root of (cache' + epsilon) * 2^14, then the step division.
   logic [63:0]       sq_x;
   rcu_pkg::tail_type sq_tail, sq_out_tail, dv_out_tail;
   logic              sq_out_valid, dv_out_valid;
   logic [31:0]       sq_root;
   logic [54:0]       sq_num;
   logic [33:0]       dv_step;

   always_comb begin
      sq_x               = {(50'(s4_cnew_ff) + 50'(epsilon_ff)), 14'd0};
      sq_tail.weight     = s4_w_ff;
      sq_tail.reg_mag    = s4_reg_ff;
      sq_tail.grad_neg   = s4_gneg_ff;
      sq_tail.clipped    = s4_clip_ff;
      sq_tail.cache_new  = s4_cnew_ff;
      sq_tail.clip_total = s4_ct_ff;
      sq_tail.elem_total = s4_et_ff;
   end

   rcu_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_x      (sq_x),
      .in_num    (s4_num_ff),
      .in_tail   (sq_tail),
      .out_valid (sq_out_valid),
      .out_root  (sq_root),
      .out_num   (sq_num),
      .out_tail  (sq_out_tail)
   );

   rcu_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_out_valid),
      .in_num    (sq_num),
      .in_root   (sq_root),
      .in_tail   (sq_out_tail),
      .out_valid (dv_out_valid),
      .out_step  (dv_step),
      .out_tail  (dv_out_tail)
   );

   // Final weight: subtract signed step and regularization, then saturate.
   logic signed [36:0] w_ext, step_s, reg_s, nw;
   logic signed [31:0] weight_in_v;

   always_comb begin
      w_ext  = 37'(dv_out_tail.weight);
      step_s = $signed({3'b000, dv_step});
      reg_s  = $signed({6'd0, dv_out_tail.reg_mag});
      if (dv_out_tail.grad_neg) step_s = -step_s;
      if (dv_out_tail.weight[31]) reg_s = -reg_s;
      nw = w_ext - step_s - reg_s;
      if (nw > 37'sd2147483647) begin
         weight_in_v = 32'sh7FFF_FFFF;
      end else if (nw < -37'sd2147483648) begin
         weight_in_v = 32'sh8000_0000;
      end else begin
         weight_in_v = nw[31:0];
      end
   end

   logic signed [31:0] weight_out_ff;
   logic [47:0]        cache_out_ff;
   logic               clipped_out_ff;
   logic [31:0]        ct_out_ff, et_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_out_ff  <= weight_in_v;
         cache_out_ff   <= dv_out_tail.cache_new;
         clipped_out_ff <= dv_out_tail.clipped;
         ct_out_ff      <= dv_out_tail.clip_total;
         et_out_ff      <= dv_out_tail.elem_total;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_weight_out    = weight_out_ff;
   assign rsp_cache_out     = cache_out_ff;
   assign rsp_was_clipped   = clipped_out_ff;
   assign rsp_clipped_total = ct_out_ff;
   assign rsp_element_total = et_out_ff;

endmodule

// ===== hw/rtl/rcu_checker.sv =====
// Port-level checks of the update unit, bound to the top level.
module rcu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_weight_out,
   input logic               rsp_was_clipped,
   input logic [31:0]        rsp_clipped_total
);

   // No result can be pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_out))
      else $error("stalled result changed");

   // The input is held back exactly when a result is stuck at the output.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   // A clipped element always counts itself.
   a_clip_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_clipped |-> rsp_clipped_total != 32'd0)
      else $error("clipped result with zero clip count");

endmodule

bind rmsprop_clipped_update_unit rcu_checker u_rcu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_weight_out    (rsp_weight_out),
   .rsp_was_clipped   (rsp_was_clipped),
   .rsp_clipped_total (rsp_clipped_total)
);

// ===== tb/rmsprop_clipped_update_unit_tb.sv =====
// Self-checking testbench of the RMSprop clipped update unit.
`timescale 1ns / 1ps

module rmsprop_clipped_update_unit_tb;

   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic               start_pass;
      logic signed [31:0] weight;
      logic signed [31:0] grad;
      logic [47:0]        cache;
   } update_req_type;

   typedef struct {
      logic signed [31:0] weight;
      logic [47:0]        cache;
      logic               clipped;
      logic [31:0]        clip_total;
      logic [31:0]        elem_total;
   } update_rsp_type;

   // One row of the directed table; has_known marks rows with a typed-in result.
   typedef struct {
      update_req_type req;
      bit             has_known;
      update_rsp_type known;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_start_pass;
   logic signed [31:0] req_weight_in;
   logic signed [31:0] req_grad_in;
   logic [47:0]        req_cache_in;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_weight_out;
   logic [47:0]        rsp_cache_out;
   logic               rsp_was_clipped;
   logic [31:0]        rsp_clipped_total;
   logic [31:0]        rsp_element_total;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [4:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   rmsprop_clipped_update_unit dut (.*);

   // Configuration and counters as the predictor sees them.
   logic [24:0] cfg_rate;
   logic [24:0] cfg_decay;
   logic [30:0] cfg_clip;
   logic [31:0] cfg_wdecay;
   logic [31:0] cfg_eps;
   logic [31:0] pred_clip_count;
   logic [31:0] pred_elem_count;

   update_rsp_type expected_updates[$];
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   bit          timed_out;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   bit          hold_off;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Computes the updated weight, cache and pass totals for one element.
   function automatic update_rsp_type predict_update(input update_req_type r);
      update_rsp_type o;
      logic [63:0] d, od, rate, gmag, g2, t1, t2, cnew, gcm, num, root, stepm, wm, regm;
      logic signed [63:0] w, g, gc, c, nw;
      logic clipped;
      w = r.weight;
      g = r.grad;
      d = (cfg_decay > rcu_pkg::ONE_Q24) ? 64'(rcu_pkg::ONE_Q24) : 64'(cfg_decay);
      od = 64'(rcu_pkg::ONE_Q24) - d;
      rate = (cfg_rate > rcu_pkg::ONE_Q24) ? 64'(rcu_pkg::ONE_Q24) : 64'(cfg_rate);
      gmag = (g < 0) ? 64'(-g) : 64'(g);
      g2 = gmag * gmag;
      t1 = (64'(r.cache) >> 24) * d + (((64'(r.cache) & 64'hFF_FFFF) * d) >> 24);
      t2 = (g2 >> 40) * od + (((g2 & 64'hFF_FFFF_FFFF) * od) >> 40);
      cnew = t1 + t2;
      if (cnew > 64'(rcu_pkg::CACHE_MAX)) cnew = 64'(rcu_pkg::CACHE_MAX);
      c = 64'(cfg_clip);
      clipped = 1'b0;
      gc = g;
      if (g > c) begin
         gc = c;
         clipped = 1'b1;
      end else if (g < -c) begin
         gc = -c;
         clipped = 1'b1;
      end
      gcm = (gc < 0) ? 64'(-gc) : 64'(gc);
      num = rate * gcm;
      root = int_sqrt((cnew + 64'(cfg_eps)) << 14);
      if (num == 0) stepm = 0;
      else if (root == 0) stepm = 64'(rcu_pkg::STEP_LIMIT);
      else stepm = num / (2 * root);
      if (stepm > 64'(rcu_pkg::STEP_LIMIT)) stepm = 64'(rcu_pkg::STEP_LIMIT);
      wm = (w < 0) ? 64'(-w) : 64'(w);
      regm = (64'(cfg_wdecay) * wm) >> 32;
      nw = w;
      nw = (gc < 0) ? nw + $signed(stepm) : nw - $signed(stepm);
      nw = (w < 0) ? nw + $signed(regm) : nw - $signed(regm);
      if (nw > 64'sd2147483647) nw = 64'sd2147483647;
      if (nw < -64'sd2147483648) nw = -64'sd2147483648;
      if (r.start_pass) begin
         pred_clip_count = 0;
         pred_elem_count = 0;
      end
      if (clipped) pred_clip_count = pred_clip_count + 1;
      pred_elem_count = pred_elem_count + 1;
      o.weight = nw[31:0];
      o.cache = cnew[47:0];
      o.clipped = clipped;
      o.clip_total = pred_clip_count;
      o.elem_total = pred_elem_count;
      return o;
   endfunction

   // Setup and access cycles of one write; the caller returns the port to idle.
   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      unique case (index)
         rcu_pkg::REG_STEP_RATE:    cfg_rate = value[24:0];
         rcu_pkg::REG_DECAY:        cfg_decay = value[24:0];
         rcu_pkg::REG_CLIP_LIMIT:   cfg_clip = value[30:0];
         rcu_pkg::REG_WEIGHT_DECAY: cfg_wdecay = value;
         rcu_pkg::REG_EPSILON:      cfg_eps = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [31:0] rate, input logic [31:0] dec,
                               input logic [31:0] clip, input logic [31:0] wd,
                               input logic [31:0] eps);
      write_csr(rcu_pkg::REG_STEP_RATE, rate);
      write_csr(rcu_pkg::REG_DECAY, dec);
      write_csr(rcu_pkg::REG_CLIP_LIMIT, clip);
      write_csr(rcu_pkg::REG_WEIGHT_DECAY, wd);
      write_csr(rcu_pkg::REG_EPSILON, eps);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Offers one request after a random gap and holds it until accepted.
   // The valid stays high afterwards so that requests can follow back to back.
   task automatic send_update(input update_req_type r, input bit has_known,
                              input update_rsp_type known);
      update_rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_pass <= r.start_pass;
      req_weight_in <= r.weight;
      req_grad_in <= r.grad;
      req_cache_in <= r.cache;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_update(r);
      if (has_known && p != known) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Directed row disagrees: exp w %h c %h, typed w %h c %h",
                     p.weight, p.cache, known.weight, known.cache);
      end
      expected_updates.push_back(has_known ? known : p);
   endtask

   function automatic update_req_type random_update();
      update_req_type r;
      int unsigned sel;
      sel = $urandom_range(9);
      r.start_pass = ($urandom_range(19) == 0);
      r.weight = $urandom;
      r.grad = (sel < 5) ? $signed(32'($urandom_range(200_000_000))) - 100_000_000
                         : $signed($urandom);
      r.cache = 48'({$urandom, $urandom});
      if (sel == 0) r.cache = r.cache & 48'hFFFF_FFFF;
      if (sel == 9) r.grad = 0;
      return r;
   endfunction

   task automatic drain_updates();
      req_valid <= 1'b0;
      while (expected_updates.size() != 0 && !timed_out) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off requested by the sender.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         update_rsp_type e;
         if (expected_updates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected update result");
         end else begin
            e = expected_updates.pop_front();
            if (e.weight !== rsp_weight_out || e.cache !== rsp_cache_out ||
                e.clipped !== rsp_was_clipped || e.clip_total !== rsp_clipped_total ||
                e.elem_total !== rsp_element_total) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: exp w %h c %h k %b ct %0d et %0d, got w %h c %h k %b ct %0d et %0d",
                           e.weight, e.cache, e.clipped, e.clip_total, e.elem_total,
                           rsp_weight_out, rsp_cache_out, rsp_was_clipped,
                           rsp_clipped_total, rsp_element_total);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted request on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      update_rsp_type none;
      int unsigned phase;
      int unsigned count;
      none = '{default: 0};
      timed_out = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_pass = 1'b0;
      req_weight_in = 0;
      req_grad_in = 0;
      req_cache_in = 0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 0;
      pwdata = 0;
      cfg_rate = rcu_pkg::RST_STEP_RATE;
      cfg_decay = rcu_pkg::RST_DECAY;
      cfg_clip = rcu_pkg::RST_CLIP_LIMIT;
      cfg_wdecay = rcu_pkg::RST_WEIGHT_DECAY;
      cfg_eps = rcu_pkg::RST_EPSILON;
      pred_clip_count = 0;
      pred_elem_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset settings: zeros, extremes, clip both ways.
      row.has_known = 1'b1;
      row.req = '{1'b1, 32'sd0, 32'sd0, 48'd0};
      row.known = '{32'sd0, 48'd0, 1'b0, 32'd0, 32'd1};
      rows.push_back(row);
      row.has_known = 1'b0;
      row.known = none;
      row.req = '{1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF};
      rows.push_back(row);
      row.req = '{1'b0, 32'sh8000_0000, 32'sh8000_0000, 48'hFFFF_FFFF_FFFF};
      rows.push_back(row);
      row.req = '{1'b0, 32'sh0100_0000, 32'sd83886080, 48'h1_0000_0000};
      rows.push_back(row);
      row.req = '{1'b0, -32'sh0100_0000, 32'sd83886081, 48'h0};
      rows.push_back(row);
      row.req = '{1'b0, 32'sd12345, -32'sd83886081, 48'hFFFF};
      rows.push_back(row);
      row.req = '{1'b1, -32'sd1, 32'sd1, 48'd1};
      rows.push_back(row);
      row.req = '{1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, 48'h5555_5555_5555};
      rows.push_back(row);
      row.req = '{1'b0, 32'shAAAA_AAAA, 32'sh5555_5555, 48'hAAAA_AAAA_AAAA};
      rows.push_back(row);
      foreach (rows[i]) send_update(rows[i].req, rows[i].has_known, rows[i].known);
      drain_updates();

      // Zero root and fractions above one; epsilon zero gives full-magnitude steps.
      apply_config(32'h1FF_FFFF, 32'h1FF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      rows.delete();
      row.has_known = 1'b1;
      row.req = '{1'b1, 32'sd0, 32'sd5, 48'd0};
      row.known = '{32'sh8000_0000, 48'd0, 1'b0, 32'd0, 32'd1};
      rows.push_back(row);
      row.req = '{1'b0, 32'sd0, -32'sd5, 48'd0};
      row.known = '{32'sh7FFF_FFFF, 48'd0, 1'b0, 32'd0, 32'd2};
      rows.push_back(row);
      row.has_known = 1'b0;
      row.known = none;
      row.req = '{1'b0, 32'sh7FFF_FFFF, 32'sd0, 48'd0};
      rows.push_back(row);
      row.req = '{1'b0, 32'sh8000_0000, 32'sh8000_0000, 48'hFFFF_FFFF_FFFF};
      rows.push_back(row);
      foreach (rows[i]) send_update(rows[i].req, rows[i].has_known, rows[i].known);
      drain_updates();
      apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      row.req = '{1'b0, 32'sd1000, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF};
      send_update(row.req, 1'b0, none);
      row.req = '{1'b0, -32'sd1000, -32'sd1, 48'd7};
      send_update(row.req, 1'b0, none);
      drain_updates();

      // Random phases, each with its own settings and idling pattern.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            3: begin send_idle_pct = 26; stall_pct = 26; end
            default: begin send_idle_pct = $urandom_range(30); stall_pct = $urandom_range(30); end
         endcase
         if (phase == 0)
            apply_config(rcu_pkg::RST_STEP_RATE, rcu_pkg::RST_DECAY, rcu_pkg::RST_CLIP_LIMIT,
                         rcu_pkg::RST_WEIGHT_DECAY, rcu_pkg::RST_EPSILON);
         else
            apply_config($urandom_range(32'h100_0000), $urandom_range(32'h100_0000),
                         $urandom & 32'h0FFF_FFFF, $urandom_range(1 << 20) << $urandom_range(11),
                         $urandom_range(1000) << $urandom_range(20));
         for (count = 0; count < 155; count++) begin
            // Hold the receiver off long enough in phase 0 to fill the pipeline.
            if (phase == 0 && count == 10) begin
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (150) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
            send_update(random_update(), 1'b0, none);
         end
         drain_updates();
      end

      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
